// ----- rtl/icbd_pkg.sv -----
// Package for the IDE card bus decoder: item types, field codes and constants.
// Used by the front end, back end and top level; depends on nothing.
package icbd_pkg;

  // card space and SRAM page geometry
  localparam int unsigned ADDR_W     = 13;
  localparam int unsigned PAGE_BYTES = 8192;

  // access types
  localparam logic [1:0] OP_CTRL_RD = 2'd0;
  localparam logic [1:0] OP_CTRL_WR = 2'd1;
  localparam logic [1:0] OP_MEM_RD  = 2'd2;
  localparam logic [1:0] OP_MEM_WR  = 2'd3;

  // drive and clock chip cycle codes
  localparam logic [1:0] CYC_NONE  = 2'd0;
  localparam logic [1:0] CYC_READ  = 2'd1;
  localparam logic [1:0] CYC_WRITE = 2'd2;

  // configuration register indexes
  localparam logic CFG_WORD_ORDER  = 1'b0;
  localparam logic CFG_SRAM_SWITCH = 1'b1;

  // control bit indexes
  localparam logic [2:0] CB_SRAM_SEL   = 3'd1;
  localparam logic [2:0] CB_PAGE_SW    = 3'd2;
  localparam logic [2:0] CB_PAGE_FORCE = 3'd3;
  localparam logic [2:0] CB_WPROT      = 3'd5;
  localparam logic [2:0] CB_INT_EN     = 3'd6;
  localparam logic [2:0] CB_DRV_RST    = 3'd7;

  // clock chip targets
  localparam logic CLK_TGT_XRAM = 1'b0;
  localparam logic CLK_TGT_REGS = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [12:0] address;
    logic [2:0]  control_bit;
    logic [7:0]  write_byte;
    logic [15:0] drive_word;
    logic [7:0]  clock_byte;
    logic        drive_irq;
    logic        clock_irq;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [1:0]  drive_cycle;
    logic        drive_chip_set;
    logic [2:0]  drive_register;
    logic [15:0] drive_write_word;
    logic [1:0]  clock_cycle;
    logic        clock_target;
    logic [5:0]  clock_address;
    logic [7:0]  clock_write_byte;
    logic        drive_int_line;
    logic        clock_int_line;
    logic        drive_reset_pulse;
  } out_item_t;

  // decoded item handed from front to back (SRAM index travels beside it)
  typedef struct packed {
    out_item_t  res;
    logic       ram_rd;
    logic       ram_wr;
    logic [7:0] wdata;
  } cmd_t;

endpackage

// ----- rtl/icbd_ram.sv -----
// Generic single-port RAM with registered read data.
// Stand-alone; no package needed.
module icbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/icbd_fifo.sv -----
// Small register FIFO with fill count, used for the item queues.
// Stand-alone; no package needed.
module icbd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/icbd_front.sv -----
// Front end: accepts bus accesses, keeps control state and IDE latches,
// decodes each item and forms its result except SRAM read data. Uses icbd_pkg.
module icbd_front #(
  parameter int unsigned PAGE_BITS = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic                             cfg_wdata_i,
  input  logic                             accept_i,
  input  icbd_pkg::in_item_t               item_i,
  output icbd_pkg::cmd_t                   cmd_o,
  output logic [icbd_pkg::ADDR_W+PAGE_BITS-1:0] idx_o
);

  import icbd_pkg::*;

  localparam int unsigned IDX_W = ADDR_W + PAGE_BITS;

  logic                 word_order_q, sram_switch_q;
  logic                 sram_sel_q, sram_sel_d;
  logic [7:0]           cb_q, cb_d;
  logic [PAGE_BITS-1:0] page_q, page_d;
  logic [15:0]          rlatch_q, rlatch_d;
  logic [15:0]          wlatch_q, wlatch_d;
  logic                 wr, odd, trig;
  logic [1:0]           sel;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_order_q  <= 1'b0;
      sram_switch_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WORD_ORDER:  word_order_q  <= cfg_wdata_i;
        CFG_SRAM_SWITCH: sram_switch_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // decode one access
  always_comb begin
    sram_sel_d = sram_sel_q;
    cb_d       = cb_q;
    page_d     = page_q;
    rlatch_d   = rlatch_q;
    wlatch_d   = wlatch_q;
    cmd_o      = '0;
    idx_o      = '0;
    wr         = (item_i.operation == OP_MEM_WR);
    odd        = item_i.address[0];
    sel        = item_i.address[6:5];
    trig       = 1'b0;

    case (item_i.operation)
      OP_CTRL_RD: begin
        cmd_o.res.read_byte = {2'b00, cb_q[5:4], 1'b1, !item_i.clock_irq,
                               sram_switch_q, !item_i.drive_irq};
      end
      OP_CTRL_WR: begin
        if (item_i.control_bit == CB_SRAM_SEL) begin
          sram_sel_d = |item_i.write_byte;
        end else if (item_i.control_bit >= CB_PAGE_SW) begin
          cb_d[item_i.control_bit] = |item_i.write_byte;
          cmd_o.res.drive_reset_pulse = (item_i.control_bit == CB_INT_EN ||
                                         item_i.control_bit == CB_DRV_RST) &&
                                        cb_d[CB_INT_EN] && !cb_d[CB_DRV_RST];
        end
      end
      default: begin
        // page switching on memory writes
        if (wr && cb_q[CB_PAGE_SW]) begin
          page_d = item_i.address[PAGE_BITS:1];
        end
        if (item_i.address <= 13'h0ff && sram_sel_q == sram_switch_q) begin
          if (!sel[1]) begin
            // clock chip
            cmd_o.res.clock_cycle = wr ? CYC_WRITE : CYC_READ;
            if (!sel[0]) begin
              cmd_o.res.clock_target  = CLK_TGT_XRAM;
              cmd_o.res.clock_address = item_i.address[7] ?
                {1'b1, item_i.address[4:0]} : item_i.address[5:0];
            end else begin
              cmd_o.res.clock_target  = CLK_TGT_REGS;
              cmd_o.res.clock_address = {5'b0, item_i.address[4]};
            end
            if (wr) cmd_o.res.clock_write_byte = item_i.write_byte;
            else    cmd_o.res.read_byte        = item_i.clock_byte;
          end else if (!wr) begin
            // IDE read through the read latch
            trig = word_order_q ? !odd : odd;
            if (trig) begin
              if (!item_i.address[4]) begin
                rlatch_d                  = item_i.drive_word;
                cmd_o.res.drive_cycle     = CYC_READ;
                cmd_o.res.drive_chip_set  = sel[0];
                cmd_o.res.drive_register  = item_i.address[3:1];
              end else begin
                rlatch_d = '0;
              end
            end
            cmd_o.res.read_byte = odd ? rlatch_d[15:8] : rlatch_d[7:0];
          end else begin
            // IDE write through the write latch
            trig = word_order_q ? odd : !odd;
            if (odd) wlatch_d = {item_i.write_byte, wlatch_q[7:0]};
            else     wlatch_d = {wlatch_q[15:8], item_i.write_byte};
            if (trig) begin
              cmd_o.res.drive_cycle      = CYC_WRITE;
              cmd_o.res.drive_chip_set   = sel[0];
              cmd_o.res.drive_register   = item_i.address[3:1];
              cmd_o.res.drive_write_word = wlatch_d;
            end
          end
        end else begin
          // paged SRAM; data handled in the back end
          if (cb_q[CB_PAGE_FORCE] || item_i.address[12]) begin
            idx_o = {page_d, item_i.address};
          end else begin
            idx_o = IDX_W'(item_i.address);
          end
          cmd_o.ram_wr = wr && !cb_q[CB_WPROT];
          cmd_o.ram_rd = !wr;
          cmd_o.wdata  = item_i.write_byte;
        end
      end
    endcase

    cmd_o.res.drive_int_line = cb_d[CB_INT_EN] && item_i.drive_irq;
    cmd_o.res.clock_int_line = item_i.clock_irq;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sram_sel_q <= 1'b0;
      cb_q       <= '0;
      page_q     <= '0;
      rlatch_q   <= '0;
      wlatch_q   <= '0;
    end else if (accept_i) begin
      sram_sel_q <= sram_sel_d;
      cb_q       <= cb_d;
      page_q     <= page_d;
      rlatch_q   <= rlatch_d;
      wlatch_q   <= wlatch_d;
    end
  end

endmodule

// ----- rtl/icbd_back.sv -----
// Back end: takes decoded items from the queue, performs the SRAM access,
// merges read data and buffers results. Uses icbd_pkg, icbd_ram, icbd_fifo.
module icbd_back #(
  parameter int unsigned PAGE_BITS = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_empty_i,
  input  icbd_pkg::cmd_t                   cmd_i,
  input  logic [icbd_pkg::ADDR_W+PAGE_BITS-1:0] idx_i,
  output logic                             cmd_pop_o,
  input  logic                             pop_i,
  output logic                             empty_o,
  output icbd_pkg::out_item_t              item_o
);

  import icbd_pkg::*;

  localparam int unsigned IDX_W     = ADDR_W + PAGE_BITS;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned CW        = $clog2(OUT_DEPTH + 1);
  localparam int unsigned OUT_W     = $bits(out_item_t);

  logic             s1_valid_q;
  out_item_t        s1_res_q;
  logic             s1_rd_q;
  logic [7:0]       ram_rdata;
  logic [CW-1:0]    out_cnt;
  logic [CW-1:0]    credit;
  out_item_t        merged;
  logic [OUT_W-1:0] out_rdata;
  logic             out_full;

  // take the next item only while the result buffer has room for it
  assign credit    = out_cnt + CW'(s1_valid_q);
  assign cmd_pop_o = !cmd_empty_i && (credit < CW'(OUT_DEPTH));

  icbd_ram #(
    .WIDTH (8),
    .DEPTH (PAGE_BYTES << PAGE_BITS)
  ) u_sram (
    .clk_i   (clk_i),
    .we_i    (cmd_pop_o && cmd_i.ram_wr),
    .addr_i  (idx_i[IDX_W-1:0]),
    .wdata_i (cmd_i.wdata),
    .rdata_o (ram_rdata)
  );

  // stage waiting on SRAM read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      s1_res_q <= cmd_i.res;
      s1_rd_q  <= cmd_i.ram_rd;
    end
  end

  // merge SRAM byte into the result
  always_comb begin
    merged = s1_res_q;
    if (s1_rd_q) begin
      merged.read_byte = ram_rdata;
    end
  end

  icbd_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_valid_q),
    .wdata_i (merged),
    .pop_i   (pop_i),
    .rdata_o (out_rdata),
    .full_o  (out_full),
    .empty_o (empty_o),
    .count_o (out_cnt)
  );

  // full never limits pushes here: the credit check keeps room
  assign item_o = out_item_t'(out_rdata) | {OUT_W{1'b0 & out_full}};

endmodule

// ----- rtl/ide_card_bus_decoder.sv -----
// Top level of the IDE card bus decoder: front end, item queue, back end.
// Depends on icbd_pkg, icbd_front, icbd_fifo, icbd_back.
//
// Usage:
//   Input items (one bus access each) enter with push while full is low.
//   Each item gives exactly one result, shown on out_item_o while empty is
//   low and taken with pop. Results leave in input order.
//   Configuration (word order, SRAM select switch) is written with cfg_we_i,
//   cfg_idx_i and cfg_wdata_i while no item is in flight.
// Timing:
//   One item per cycle sustained while pop keeps up. An accepted item passes
//   through the item queue, the stage that waits on the SRAM's registered
//   read port and the result buffer before its result is visible.
// Reset:
//   Control bits, page, latches and queues clear; SRAM contents are
//   undefined until written. No clearing pass is needed.
// Stalls:
//   When pop stays low, results collect in a four-entry buffer, then the
//   item queue fills and full rises; nothing is dropped.
module ide_card_bus_decoder #(
  parameter int unsigned PAGE_BITS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic                cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  icbd_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output icbd_pkg::out_item_t out_item_o
);

  import icbd_pkg::*;

  localparam int unsigned IDX_W     = ADDR_W + PAGE_BITS;
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_W     = $bits(cmd_t) + IDX_W;

  cmd_t             front_cmd, back_cmd;
  logic [IDX_W-1:0] front_idx, back_idx;
  logic [CMD_W-1:0] cmd_rdata;
  logic             cmd_full, cmd_empty, cmd_pop, accept;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_cnt;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  icbd_front #(
    .PAGE_BITS (PAGE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .cmd_o       (front_cmd),
    .idx_o       (front_idx)
  );

  icbd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i ({front_cmd, front_idx}),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .full_o  (cmd_full),
    .empty_o (cmd_empty),
    .count_o (cmd_cnt)
  );

  assign back_cmd = cmd_t'(cmd_rdata[CMD_W-1:IDX_W]);
  assign back_idx = cmd_rdata[IDX_W-1:0];

  icbd_back #(
    .PAGE_BITS (PAGE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (back_cmd),
    .idx_i       (back_idx),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .item_o      (out_item_o)
  );

  // back end only draws from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("item queue popped while empty");

  // queue count agrees with its full flag
  a_cnt_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_full |-> (cmd_cnt == 2'(CMD_DEPTH)))
    else $error("item queue full flag and count disagree");

  // a result never drives both the drive and the clock chip
  a_one_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(out_item_o.drive_cycle != CYC_NONE &&
                 out_item_o.clock_cycle != CYC_NONE))
    else $error("result addresses drive and clock chip together");

  // a drive reset comes only from a control write
  a_rst_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.drive_reset_pulse) |->
      (out_item_o.drive_cycle == CYC_NONE && out_item_o.clock_cycle == CYC_NONE))
    else $error("drive reset pulse on a memory access");

endmodule
